/* sv/dpad_auto_repeat_direction_defines.svh */
// assertion helpers for the dpad auto-repeat core (dpad_ar_core)
`ifndef DPAD_AUTO_REPEAT_DIRECTION_DEFINES_SVH
`define DPAD_AUTO_REPEAT_DIRECTION_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DPAD_AR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define DPAD_AR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dpad_ar_pkg.sv */
package dpad_ar_pkg;

	localparam int LVL_W = 5;
	localparam int LVL_UP = 0;
	localparam int LVL_DOWN = 1;
	localparam int LVL_LEFT = 2;
	localparam int LVL_RIGHT = 3;
	localparam int LVL_MOD = 4;

	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;
	localparam int PERIOD_W = 7;

	localparam logic [7:0] DELAY_RESET = 8'd12;
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd5;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_DELAY = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = 1'b1;

	localparam logic [3:0] DIR_CENTER = 4'd0;
	localparam logic [3:0] DIR_N = 4'd1;
	localparam logic [3:0] DIR_S = 4'd2;
	localparam logic [3:0] DIR_W = 4'd3;
	localparam logic [3:0] DIR_E = 4'd4;
	localparam logic [3:0] DIR_NE = 4'd5;
	localparam logic [3:0] DIR_NW = 4'd6;
	localparam logic [3:0] DIR_SE = 4'd7;
	localparam logic [3:0] DIR_SW = 4'd8;

	typedef logic [LVL_W-1:0] levels_t;

	typedef struct packed {
		logic up_held;
		logic down_held;
		logic left_held;
		logic right_held;
		logic modifier_held;
	} sample_t;

	typedef struct packed {
		logic [3:0] direction;
		logic repeat_fired;
		logic modifier_tap_alone;
	} result_t;

	typedef struct packed {
		levels_t cur;
		levels_t pressed;
		logic fire;
		logic tap;
	} frame_t;

endpackage

/* sv/dpad_auto_repeat_direction.sv */
// channel  | handshake                   | payload
// sample   | sample_valid / sample_ready | sample (sample_t)
// result   | result_valid / result_ready | result (result_t)
// cfg      | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// one sample per cycle sustained while the result is not stalled; result_valid rises once its sample has
// passed through the sample register and then the result register; hold state updates once per frame
// arst_n clears hold state, valids and loads delay 12, period 5
// a stalled result holds the frame in the sample register; sample_ready drops only then
// cfg_ready is always high
module dpad_auto_repeat_direction
	import dpad_ar_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_ready,
	input  sample_t sample,
	output logic result_valid,
	input  logic result_ready,
	output result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic [CNT_W-1:0] delay_q;
	logic [PERIOD_W-1:0] period_q;
	logic valid_s1;
	sample_t sample_s1;
	logic res_valid_q;
	result_t res_q;
	logic advance;
	levels_t cur;
	frame_t frame;
	logic [3:0] direction;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q <= DELAY_RESET;
			period_q <= PERIOD_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_INITIAL_DELAY: delay_q <= cfg_data;
				CFG_REPEAT_PERIOD: period_q <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance = valid_s1 && (!res_valid_q || result_ready);
	assign sample_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			sample_s1 <= sample;
		end
	end

	always_comb begin
		cur = '0;
		cur[LVL_UP] = sample_s1.up_held;
		cur[LVL_DOWN] = sample_s1.down_held;
		cur[LVL_LEFT] = sample_s1.left_held;
		cur[LVL_RIGHT] = sample_s1.right_held;
		cur[LVL_MOD] = sample_s1.modifier_held;
	end

	dpad_ar_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.en(advance),
		.cur(cur),
		.initial_delay(delay_q),
		.repeat_period(period_q),
		.frame(frame)
	);

	dpad_ar_dir u_dir (
		.frame(frame),
		.direction(direction)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q.direction <= direction;
			res_q.repeat_fired <= frame.fire;
			res_q.modifier_tap_alone <= frame.tap;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

endmodule

/* sv/dpad_ar_core.sv */
`include "dpad_auto_repeat_direction_defines.svh"

module dpad_ar_core
	import dpad_ar_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  levels_t cur,
	input  logic [CNT_W-1:0] initial_delay,
	input  logic [PERIOD_W-1:0] repeat_period,
	output frame_t frame
);

	levels_t prev_q;
	logic [CNT_W-1:0] cnt_q;
	logic rep_q;
	logic hu_q;

	levels_t pressed;
	levels_t released;
	logic dpad_any;
	logic pad_press;
	logic [CNT_W-1:0] cnt_upd;
	logic rep_upd;
	logic hu_upd;
	logic [CNT_W:0] rep_lim;
	logic fire;
	logic [CNT_W-1:0] cnt_nxt;
	logic rep_nxt;

	assign pressed = cur & ~prev_q;
	assign released = prev_q & ~cur;
	assign dpad_any = |cur[LVL_RIGHT:LVL_UP];
	assign pad_press = |pressed[LVL_RIGHT:LVL_UP];

	always_comb begin
		if (!dpad_any) begin
			cnt_upd = '0;
		end else if (cnt_q == CNT_MAX) begin
			cnt_upd = cnt_q;
		end else begin
			cnt_upd = cnt_q + 1'b1;
		end
	end

	assign rep_upd = dpad_any & rep_q;

	always_comb begin
		hu_upd = hu_q;
		if (pressed[LVL_MOD]) begin
			hu_upd = 1'b0;
		end
		if (cur[LVL_MOD] && pad_press) begin
			hu_upd = 1'b1;
		end
	end

	assign rep_lim = {1'b0, initial_delay} + {2'b00, repeat_period};
	assign fire = dpad_any && (cnt_upd >= initial_delay)
		&& (!rep_upd || ({1'b0, cnt_upd} >= rep_lim));
	assign cnt_nxt = fire ? initial_delay : cnt_upd;
	assign rep_nxt = fire | rep_upd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			cnt_q <= '0;
			rep_q <= 1'b0;
			hu_q <= 1'b0;
		end else if (en) begin
			prev_q <= cur;
			cnt_q <= cnt_nxt;
			rep_q <= rep_nxt;
			hu_q <= hu_upd;
		end
	end

	assign frame.cur = cur;
	assign frame.pressed = pressed;
	assign frame.fire = fire;
	assign frame.tap = released[LVL_MOD] & ~hu_upd;

	`DPAD_AR_ASSERT_NXT(a_release_clears, en && !dpad_any, cnt_q == '0 && !rep_q,
		"hold state not cleared after all directions released")
	`DPAD_AR_ASSERT_NXT(a_fire_reloads, en && fire, cnt_q == $past(initial_delay) && rep_q,
		"counter not reloaded after a repeat")
	`DPAD_AR_ASSERT_IMP(a_count_needs_hold, cnt_q != '0 || rep_q, prev_q[LVL_RIGHT:LVL_UP] != '0,
		"hold state set with no direction held")

endmodule

/* sv/dpad_ar_dir.sv */
module dpad_ar_dir
	import dpad_ar_pkg::*;
(
	input  frame_t frame,
	output logic [3:0] direction
);

	levels_t c;
	levels_t p;
	logic f;
	logic ne;
	logic nw;
	logic se;
	logic sw;

	assign c = frame.cur;
	assign p = frame.pressed;
	assign f = frame.fire;

	assign ne = c[LVL_UP] & c[LVL_RIGHT] & (p[LVL_UP] | p[LVL_RIGHT] | f);
	assign nw = c[LVL_UP] & c[LVL_LEFT] & (p[LVL_UP] | p[LVL_LEFT] | f);
	assign se = c[LVL_DOWN] & c[LVL_RIGHT] & (p[LVL_DOWN] | p[LVL_RIGHT] | f);
	assign sw = c[LVL_DOWN] & c[LVL_LEFT] & (p[LVL_DOWN] | p[LVL_LEFT] | f);

	// diagonals win only while the modifier is held
	always_comb begin
		if (c[LVL_MOD] && ne) begin
			direction = DIR_NE;
		end else if (c[LVL_MOD] && nw) begin
			direction = DIR_NW;
		end else if (c[LVL_MOD] && se) begin
			direction = DIR_SE;
		end else if (c[LVL_MOD] && sw) begin
			direction = DIR_SW;
		end else if (p[LVL_UP] || (f && c[LVL_UP])) begin
			direction = DIR_N;
		end else if (p[LVL_DOWN] || (f && c[LVL_DOWN])) begin
			direction = DIR_S;
		end else if (p[LVL_LEFT] || (f && c[LVL_LEFT])) begin
			direction = DIR_W;
		end else if (p[LVL_RIGHT] || (f && c[LVL_RIGHT])) begin
			direction = DIR_E;
		end else begin
			direction = DIR_CENTER;
		end
	end

endmodule
